### design/byuv_pkg.sv
// shared types, codes and color math for the bgr to planar yuv subsampler
// no dependencies; every other design file refers to this package by scoped names
package byuv_pkg;

   // defaults for the top level parameters
   localparam int DEF_MAX_DIMENSION = 4096;
   localparam int DEF_PAD_ALIGN     = 16;

   // field widths fixed by the interface
   localparam int CFG_W    = 13;
   localparam int ADDR_W   = 24;
   localparam int SAMPLE_W = 8;
   localparam int MIX_W    = 26;

   // csr register indexes
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] REG_CHROMA_MODE  = 2'd2;

   localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd640;
   localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd480;

   // chroma subsampling modes
   localparam logic [1:0] MODE_420 = 2'd0;
   localparam logic [1:0] MODE_422 = 2'd1;
   localparam logic [1:0] MODE_444 = 2'd2;

   typedef enum logic [1:0] {
      PLANE_LUMA     = 2'd0,
      PLANE_CHROMA_U = 2'd1,
      PLANE_CHROMA_V = 2'd2
   } plane_type;

   typedef struct packed {
      plane_type             plane;
      logic [ADDR_W-1:0]     address;
      logic [SAMPLE_W-1:0]   sample;
      logic                  last_of_pixel;
      logic                  end_of_frame;
   } wr_type;

   // q16 color coefficients, the chroma offsets hold 127.5 and the luma offset is zero
   localparam logic signed [MIX_W-1:0] K_Y_RED   = 26'sd19595;
   localparam logic signed [MIX_W-1:0] K_Y_GREEN = 26'sd38470;
   localparam logic signed [MIX_W-1:0] K_Y_BLUE  = 26'sd7471;
   localparam logic signed [MIX_W-1:0] K_Y_OFS   = 26'sd0;
   localparam logic signed [MIX_W-1:0] K_U_RED   = -26'sd11058;
   localparam logic signed [MIX_W-1:0] K_U_GREEN = -26'sd21710;
   localparam logic signed [MIX_W-1:0] K_U_BLUE  = 26'sd32768;
   localparam logic signed [MIX_W-1:0] K_U_OFS   = 26'sd8355840;
   localparam logic signed [MIX_W-1:0] K_V_RED   = 26'sd32768;
   localparam logic signed [MIX_W-1:0] K_V_GREEN = -26'sd27439;
   localparam logic signed [MIX_W-1:0] K_V_BLUE  = -26'sd5329;
   localparam logic signed [MIX_W-1:0] K_V_OFS   = 26'sd8355840;

   function automatic logic signed [MIX_W-1:0] mix(
      input logic [SAMPLE_W-1:0]        blue,
      input logic [SAMPLE_W-1:0]        green,
      input logic [SAMPLE_W-1:0]        red,
      input logic signed [MIX_W-1:0]    k_blue,
      input logic signed [MIX_W-1:0]    k_green,
      input logic signed [MIX_W-1:0]    k_red,
      input logic signed [MIX_W-1:0]    offset
   );
      logic signed [MIX_W-1:0] sb;
      logic signed [MIX_W-1:0] sg;
      logic signed [MIX_W-1:0] sr;
      sb = $signed(MIX_W'(blue));
      sg = $signed(MIX_W'(green));
      sr = $signed(MIX_W'(red));
      return offset + k_red * sr + k_green * sg + k_blue * sb;
   endfunction

   // negative gives zero, otherwise drop the fraction and saturate at 255
   function automatic logic [SAMPLE_W-1:0] to_sample(input logic signed [MIX_W-1:0] acc);
      logic [SAMPLE_W-1:0] res;
      if (acc[MIX_W-1]) begin
         res = '0;
      end else if (|acc[MIX_W-2:24]) begin
         res = '1;
      end else begin
         res = acc[23:16];
      end
      return res;
   endfunction

endpackage

### design/byuv_cfg.sv
// configuration registers, dimension clipping and padded stride computation
// depends on byuv_pkg
module byuv_cfg #(
   parameter int MAX_DIMENSION = byuv_pkg::DEF_MAX_DIMENSION,
   parameter int PAD_ALIGN     = byuv_pkg::DEF_PAD_ALIGN,
   localparam int DIM_W        = $clog2(MAX_DIMENSION + 1),
   localparam int STRIDE_W     = $clog2(MAX_DIMENSION + PAD_ALIGN)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [byuv_pkg::CFG_W-1:0] csr_wdata,
   output logic [DIM_W-1:0]           width_out,
   output logic [DIM_W-1:0]           height_out,
   output logic [1:0]                 mode_out,
   output logic [STRIDE_W-1:0]        stride_out,
   output logic                       busy
);
   localparam int REC_SH = STRIDE_W;
   localparam int REC_W  = REC_SH + 1;
   localparam int PROD_W = STRIDE_W + REC_W;
   localparam int RECIP  = (2 ** REC_SH) / PAD_ALIGN;

   logic [byuv_pkg::CFG_W-1:0] width_ff;
   logic [byuv_pkg::CFG_W-1:0] height_ff;
   logic [1:0]                 mode_ff;
   logic [1:0]                 settle_ff;
   logic [STRIDE_W-1:0]        padsum_ff;
   logic [STRIDE_W-1:0]        padsum_in;
   logic [STRIDE_W-1:0]        quot_ff;
   logic [STRIDE_W-1:0]        quot_in;
   logic [STRIDE_W-1:0]        stride_ff;
   logic [STRIDE_W-1:0]        stride_in;
   logic [STRIDE_W-1:0]        rem;
   logic [PROD_W-1:0]          prod;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= byuv_pkg::RST_FRAME_WIDTH;
         height_ff <= byuv_pkg::RST_FRAME_HEIGHT;
         mode_ff   <= byuv_pkg::MODE_420;
         settle_ff <= 2'd2;
      end else begin
         if (csr_valid && csr_ready) begin
            settle_ff <= 2'd2;
            case (csr_index)
               byuv_pkg::REG_FRAME_WIDTH:  width_ff  <= csr_wdata;
               byuv_pkg::REG_FRAME_HEIGHT: height_ff <= csr_wdata;
               byuv_pkg::REG_CHROMA_MODE:  mode_ff   <= csr_wdata[1:0];
               default: ;
            endcase
         end else if (settle_ff != 2'd0) begin
            settle_ff <= settle_ff - 2'd1;
         end
      end
   end

   // zero reads as one, oversize reads as the maximum
   always_comb begin
      if (width_ff == '0) begin
         width_out = DIM_W'(1);
      end else if (int'(width_ff) > MAX_DIMENSION) begin
         width_out = DIM_W'(MAX_DIMENSION);
      end else begin
         width_out = DIM_W'(width_ff);
      end
      if (height_ff == '0) begin
         height_out = DIM_W'(1);
      end else if (int'(height_ff) > MAX_DIMENSION) begin
         height_out = DIM_W'(MAX_DIMENSION);
      end else begin
         height_out = DIM_W'(height_ff);
      end
   end

   // stride = round width up to the alignment: reciprocal estimate, then one correction
   always_comb begin
      padsum_in = STRIDE_W'(width_out) + STRIDE_W'(PAD_ALIGN - 1);
      prod      = PROD_W'(padsum_in) * PROD_W'(RECIP);
      quot_in   = STRIDE_W'(prod >> REC_SH);
      rem       = padsum_ff - STRIDE_W'(quot_ff * STRIDE_W'(PAD_ALIGN));
      if (rem >= STRIDE_W'(PAD_ALIGN)) begin
         rem = rem - STRIDE_W'(PAD_ALIGN);
      end
      stride_in = padsum_ff - rem;
   end

   always_ff @(posedge clock) begin
      padsum_ff <= padsum_in;
      quot_ff   <= quot_in;
      stride_ff <= stride_in;
   end

   assign mode_out   = mode_ff;
   assign stride_out = stride_ff;
   assign busy       = settle_ff != 2'd0;

endmodule

### design/byuv_front.sv
// input register and raster position counters
// depends on byuv_pkg
module byuv_front #(
   parameter int MAX_DIMENSION = byuv_pkg::DEF_MAX_DIMENSION,
   localparam int DIM_W        = $clog2(MAX_DIMENSION + 1),
   localparam int CNT_W        = $clog2(MAX_DIMENSION)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [3*byuv_pkg::SAMPLE_W-1:0] req_tdata,
   input  logic                          cfg_busy,
   input  logic [DIM_W-1:0]              width,
   input  logic [DIM_W-1:0]              height,
   input  logic                          take,
   output logic                          px_valid,
   output logic [byuv_pkg::SAMPLE_W-1:0] px_blue,
   output logic [byuv_pkg::SAMPLE_W-1:0] px_green,
   output logic [byuv_pkg::SAMPLE_W-1:0] px_red,
   output logic [CNT_W-1:0]              px_col,
   output logic [CNT_W-1:0]              px_row,
   output logic                          px_eof
);
   localparam int CMP_W = DIM_W + 1;
   localparam int SW    = byuv_pkg::SAMPLE_W;

   logic                 px_valid_ff;
   logic [3*SW-1:0]      pix_ff;
   logic [CNT_W-1:0]     pcol_ff;
   logic [CNT_W-1:0]     prow_ff;
   logic                 peof_ff;
   logic [CNT_W-1:0]     col_ff;
   logic [CNT_W-1:0]     col_in;
   logic [CNT_W-1:0]     row_ff;
   logic [CNT_W-1:0]     row_in;
   logic                 accept;
   logic                 eol;
   logic                 eof;

   assign req_tready = !cfg_busy && (!px_valid_ff || take);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      eol    = (CMP_W'(col_ff) + CMP_W'(1)) >= CMP_W'(width);
      eof    = eol && ((CMP_W'(row_ff) + CMP_W'(1)) >= CMP_W'(height));
      col_in = eol ? '0 : col_ff + CNT_W'(1);
      row_in = row_ff;
      if (eol) begin
         row_in = eof ? '0 : row_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_valid_ff <= 1'b0;
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         if (accept) begin
            px_valid_ff <= 1'b1;
            col_ff      <= col_in;
            row_ff      <= row_in;
         end else if (take) begin
            px_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff  <= req_tdata;
         pcol_ff <= col_ff;
         prow_ff <= row_ff;
         peof_ff <= eof;
      end
   end

   assign px_valid = px_valid_ff;
   assign px_blue  = pix_ff[SW-1:0];
   assign px_green = pix_ff[2*SW-1:SW];
   assign px_red   = pix_ff[3*SW-1:2*SW];
   assign px_col   = pcol_ff;
   assign px_row   = prow_ff;
   assign px_eof   = peof_ff;

endmodule

### design/byuv_convert.sv
// color conversion and plane address generation for one registered pixel
// depends on byuv_pkg
module byuv_convert #(
   parameter int MAX_DIMENSION = byuv_pkg::DEF_MAX_DIMENSION,
   parameter int PAD_ALIGN     = byuv_pkg::DEF_PAD_ALIGN,
   localparam int CNT_W        = $clog2(MAX_DIMENSION),
   localparam int STRIDE_W     = $clog2(MAX_DIMENSION + PAD_ALIGN)
) (
   input  logic [1:0]                    mode,
   input  logic [STRIDE_W-1:0]           stride,
   input  logic [byuv_pkg::SAMPLE_W-1:0] px_blue,
   input  logic [byuv_pkg::SAMPLE_W-1:0] px_green,
   input  logic [byuv_pkg::SAMPLE_W-1:0] px_red,
   input  logic [CNT_W-1:0]              px_col,
   input  logic [CNT_W-1:0]              px_row,
   input  logic                          px_eof,
   output byuv_pkg::wr_type              luma_wr,
   output byuv_pkg::wr_type              u_wr,
   output byuv_pkg::wr_type              v_wr,
   output logic                          keep
);
   localparam int PROD_W = CNT_W + STRIDE_W;
   localparam int SUM_W  = PROD_W + 1;

   logic [byuv_pkg::SAMPLE_W-1:0] y_smp;
   logic [byuv_pkg::SAMPLE_W-1:0] u_smp;
   logic [byuv_pkg::SAMPLE_W-1:0] v_smp;
   logic [PROD_W-1:0]             luma_prod;
   logic [PROD_W-1:0]             chroma_prod;
   logic [SUM_W-1:0]              luma_sum;
   logic [SUM_W-1:0]              chroma_sum;
   logic [CNT_W-1:0]              c_col;
   logic [CNT_W-1:0]              c_row;
   logic [STRIDE_W-1:0]           c_stride;

   always_comb begin
      y_smp = byuv_pkg::to_sample(byuv_pkg::mix(px_blue, px_green, px_red,
         byuv_pkg::K_Y_BLUE, byuv_pkg::K_Y_GREEN, byuv_pkg::K_Y_RED, byuv_pkg::K_Y_OFS));
      u_smp = byuv_pkg::to_sample(byuv_pkg::mix(px_blue, px_green, px_red,
         byuv_pkg::K_U_BLUE, byuv_pkg::K_U_GREEN, byuv_pkg::K_U_RED, byuv_pkg::K_U_OFS));
      v_smp = byuv_pkg::to_sample(byuv_pkg::mix(px_blue, px_green, px_red,
         byuv_pkg::K_V_BLUE, byuv_pkg::K_V_GREEN, byuv_pkg::K_V_RED, byuv_pkg::K_V_OFS));
   end

   // mode 3 falls into the 4:2:2 arm
   always_comb begin
      case (mode)
         byuv_pkg::MODE_444: begin
            keep     = 1'b1;
            c_col    = px_col;
            c_row    = px_row;
            c_stride = stride;
         end
         byuv_pkg::MODE_420: begin
            keep     = !px_col[0] && !px_row[0];
            c_col    = px_col >> 1;
            c_row    = px_row >> 1;
            c_stride = stride >> 1;
         end
         default: begin
            keep     = !px_col[0];
            c_col    = px_col >> 1;
            c_row    = px_row;
            c_stride = stride >> 1;
         end
      endcase
   end

   always_comb begin
      luma_prod   = PROD_W'(px_row) * PROD_W'(stride);
      chroma_prod = PROD_W'(c_row) * PROD_W'(c_stride);
      luma_sum    = SUM_W'(px_col) + SUM_W'(luma_prod);
      chroma_sum  = SUM_W'(c_col) + SUM_W'(chroma_prod);
   end

   always_comb begin
      luma_wr.plane         = byuv_pkg::PLANE_LUMA;
      luma_wr.address       = byuv_pkg::ADDR_W'(luma_sum);
      luma_wr.sample        = y_smp;
      luma_wr.last_of_pixel = !keep;
      luma_wr.end_of_frame  = !keep && px_eof;

      u_wr.plane            = byuv_pkg::PLANE_CHROMA_U;
      u_wr.address          = byuv_pkg::ADDR_W'(chroma_sum);
      u_wr.sample           = u_smp;
      u_wr.last_of_pixel    = 1'b0;
      u_wr.end_of_frame     = 1'b0;

      v_wr.plane            = byuv_pkg::PLANE_CHROMA_V;
      v_wr.address          = byuv_pkg::ADDR_W'(chroma_sum);
      v_wr.sample           = v_smp;
      v_wr.last_of_pixel    = 1'b1;
      v_wr.end_of_frame     = px_eof;
   end

endmodule

### design/byuv_burst.sv
// result register holding the one or three plane writes of a pixel, sent one per cycle while rsp_tready is high
// depends on byuv_pkg
module byuv_burst (
   input  logic                clock,
   input  logic                reset,
   input  logic                px_valid,
   input  byuv_pkg::wr_type    luma_wr,
   input  byuv_pkg::wr_type    u_wr,
   input  byuv_pkg::wr_type    v_wr,
   input  logic                keep,
   output logic                take,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,  // address [23:0], sample [31:24]
   output logic [2:0]          rsp_tuser,  // plane [1:0], last_of_pixel [2]
   output logic                rsp_tlast   // end_of_frame
);
   localparam logic [1:0] SLOT_LUMA = 2'd0;
   localparam logic [1:0] SLOT_U    = 2'd1;
   localparam logic [1:0] SLOT_V    = 2'd2;

   byuv_pkg::wr_type wr_ff [3];
   byuv_pkg::wr_type cur;
   logic             bst_valid_ff;
   logic [1:0]       idx_ff;
   logic [1:0]       last_ff;
   logic             fire;
   logic             at_end;
   logic             load;

   assign fire   = bst_valid_ff && rsp_tready;
   assign at_end = idx_ff == last_ff;
   assign take   = !bst_valid_ff || (fire && at_end);
   assign load   = px_valid && take;

   always_ff @(posedge clock) begin
      if (reset) begin
         bst_valid_ff <= 1'b0;
         idx_ff       <= SLOT_LUMA;
         last_ff      <= SLOT_LUMA;
      end else begin
         if (load) begin
            bst_valid_ff <= 1'b1;
            idx_ff       <= SLOT_LUMA;
            last_ff      <= keep ? SLOT_V : SLOT_LUMA;
         end else if (fire) begin
            if (at_end) begin
               bst_valid_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         wr_ff[SLOT_LUMA] <= luma_wr;
         wr_ff[SLOT_U]    <= u_wr;
         wr_ff[SLOT_V]    <= v_wr;
      end
   end

   assign cur        = wr_ff[idx_ff];
   assign rsp_tvalid = bst_valid_ff;
   assign rsp_tdata  = {cur.sample, cur.address};
   assign rsp_tuser  = {cur.last_of_pixel, cur.plane};
   assign rsp_tlast  = cur.end_of_frame;

endmodule

### design/bgr_to_yuv_planar_subsampler.sv
// bgr to planar yuv converter with 4:2:0, 4:2:2 or 4:4:4 chroma decimation
// top level; depends on byuv_pkg, byuv_cfg, byuv_front, byuv_convert, byuv_burst
//
// usage:
//  req_*  one bgr pixel per item in raster order: blue [7:0], green [15:8], red [23:16]
//  rsp_*  plane writes: address [23:0] and sample [31:24] in tdata, plane [1:0] and
//         last_of_pixel [2] in tuser, end_of_frame on tlast; luma, then U, then V
//  csr_*  register writes: index 0 frame width, 1 frame height, 2 chroma mode
//  the first write of a pixel is offered once its item has passed the input register and
//  been loaded into the result register, and leaves while rsp_tready is high
//  a pixel giving only luma sends one write, one giving luma and chroma sends three,
//  through the single result port draining the three-entry result register
//  the next pixel is taken in the cycle the previous one's last write leaves, so
//  intake keeps pace with the output with no gap
//  after reset and after every csr write, req_tready stays low while the padded line
//  stride is recomputed (reciprocal multiply, then a correction step)
//  reset clears the column and row position and loads 640x480 in 4:2:0 mode
//  when rsp_tready is low the current write holds and one more pixel is buffered
//  in the input register before req_tready drops
module bgr_to_yuv_planar_subsampler #(
   parameter int MAX_DIMENSION = byuv_pkg::DEF_MAX_DIMENSION,
   parameter int PAD_ALIGN     = byuv_pkg::DEF_PAD_ALIGN
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [23:0]                req_tdata,  // blue [7:0], green [15:8], red [23:16]
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [31:0]                rsp_tdata,  // address [23:0], sample [31:24]
   output logic [2:0]                 rsp_tuser,  // plane [1:0], last_of_pixel [2]
   output logic                       rsp_tlast,  // end_of_frame
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [byuv_pkg::CFG_W-1:0] csr_wdata
);
   localparam int DIM_W    = $clog2(MAX_DIMENSION + 1);
   localparam int CNT_W    = $clog2(MAX_DIMENSION);
   localparam int STRIDE_W = $clog2(MAX_DIMENSION + PAD_ALIGN);

   logic [DIM_W-1:0]              width;
   logic [DIM_W-1:0]              height;
   logic [1:0]                    mode;
   logic [STRIDE_W-1:0]           stride;
   logic                          cfg_busy;
   logic                          take;
   logic                          px_valid;
   logic [byuv_pkg::SAMPLE_W-1:0] px_blue;
   logic [byuv_pkg::SAMPLE_W-1:0] px_green;
   logic [byuv_pkg::SAMPLE_W-1:0] px_red;
   logic [CNT_W-1:0]              px_col;
   logic [CNT_W-1:0]              px_row;
   logic                          px_eof;
   byuv_pkg::wr_type              luma_wr;
   byuv_pkg::wr_type              u_wr;
   byuv_pkg::wr_type              v_wr;
   logic                          keep;

   byuv_cfg #(
      .MAX_DIMENSION (MAX_DIMENSION),
      .PAD_ALIGN     (PAD_ALIGN)
   ) u_cfg (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .width_out  (width),
      .height_out (height),
      .mode_out   (mode),
      .stride_out (stride),
      .busy       (cfg_busy)
   );

   byuv_front #(
      .MAX_DIMENSION (MAX_DIMENSION)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg_busy   (cfg_busy),
      .width      (width),
      .height     (height),
      .take       (take),
      .px_valid   (px_valid),
      .px_blue    (px_blue),
      .px_green   (px_green),
      .px_red     (px_red),
      .px_col     (px_col),
      .px_row     (px_row),
      .px_eof     (px_eof)
   );

   byuv_convert #(
      .MAX_DIMENSION (MAX_DIMENSION),
      .PAD_ALIGN     (PAD_ALIGN)
   ) u_convert (
      .mode     (mode),
      .stride   (stride),
      .px_blue  (px_blue),
      .px_green (px_green),
      .px_red   (px_red),
      .px_col   (px_col),
      .px_row   (px_row),
      .px_eof   (px_eof),
      .luma_wr  (luma_wr),
      .u_wr     (u_wr),
      .v_wr     (v_wr),
      .keep     (keep)
   );

   byuv_burst u_burst (
      .clock      (clock),
      .reset      (reset),
      .px_valid   (px_valid),
      .luma_wr    (luma_wr),
      .u_wr       (u_wr),
      .v_wr       (v_wr),
      .keep       (keep),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // frame end only ever rides on a pixel's final write
   a_eof_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[2])
      else $error("end of frame on a write that is not the pixel's last");

   // a register write holds off intake while the stride settles
   a_csr_holds_intake: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_tready)
      else $error("pixel intake open right after a register write");

   // a luma write that is not last is followed at once by its U write
   a_luma_then_u: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser[1:0] == byuv_pkg::PLANE_LUMA && !rsp_tuser[2]
      |=> rsp_tvalid && rsp_tuser[1:0] == byuv_pkg::PLANE_CHROMA_U)
      else $error("luma write not followed by U write");

   // a U write is followed at once by its V write
   a_u_then_v: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser[1:0] == byuv_pkg::PLANE_CHROMA_U
      |=> rsp_tvalid && rsp_tuser[1:0] == byuv_pkg::PLANE_CHROMA_V)
      else $error("U write not followed by V write");
`endif

endmodule

### bench/bgr_to_yuv_planar_subsampler_test.sv
// self-checking bench for bgr_to_yuv_planar_subsampler: bgr pixels in, plane writes out
// needs byuv_pkg for register indexes, chroma modes and the plane write struct
// expected writes come from an independent q16 color and address predictor
module bgr_to_yuv_planar_subsampler_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIM      = 4096;
   localparam int PAD          = 16;
   localparam int LIMIT_CYCLES = 200000;

   // index 3 is not a register, mode 3 is not a defined mode
   localparam logic [1:0] REG_UNUSED    = 2'd3;
   localparam logic [1:0] MODE_RESERVED = 2'd3;

   // q16 coefficients, offset is 127.5
   localparam int Y_RED   = 19595;
   localparam int Y_GREEN = 38470;
   localparam int Y_BLUE  = 7471;
   localparam int U_RED   = -11058;
   localparam int U_GREEN = -21710;
   localparam int U_BLUE  = 32768;
   localparam int V_RED   = 32768;
   localparam int V_GREEN = -27439;
   localparam int V_BLUE  = -5329;
   localparam int CHROMA_OFS = 8355840;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [23:0]                req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [31:0]                rsp_tdata;
   logic [2:0]                 rsp_tuser;
   logic                       rsp_tlast;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [1:0]                 csr_index  = '0;
   logic [byuv_pkg::CFG_W-1:0] csr_wdata  = '0;

   // predictor copy of the block's registers and raster position
   logic [byuv_pkg::CFG_W-1:0] cfg_width  = byuv_pkg::RST_FRAME_WIDTH;
   logic [byuv_pkg::CFG_W-1:0] cfg_height = byuv_pkg::RST_FRAME_HEIGHT;
   logic [1:0]                 cfg_mode   = byuv_pkg::MODE_420;
   int                         col_pos    = 0;
   int                         row_pos    = 0;

   byuv_pkg::wr_type  pending_writes[$];

   int failures       = 0;
   int writes_checked = 0;
   int pixels_sent    = 0;
   int csr_writes     = 0;
   int cycle_count    = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_cycles        = 0;

   bgr_to_yuv_planar_subsampler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int clip_dim(input logic [byuv_pkg::CFG_W-1:0] v);
      int d;
      d = v;
      if (d == 0) d = 1;
      else if (d > MAX_DIM) d = MAX_DIM;
      return d;
   endfunction

   // negative gives zero, else drop the fraction and saturate
   function automatic logic [7:0] q16_to_byte(input int acc);
      int v;
      if (acc < 0) return 8'd0;
      v = acc >>> 16;
      return (v > 255) ? 8'd255 : 8'(v);
   endfunction

   function automatic void predict_plane_writes(input logic [7:0] blue, green, red);
      int b, g, r, w, h, stride, luma_addr, chroma_addr;
      bit keep, row_end, frame_end;
      byuv_pkg::wr_type wr;
      b = blue;
      g = green;
      r = red;
      w = clip_dim(cfg_width);
      h = clip_dim(cfg_height);
      stride = ((w + PAD - 1) / PAD) * PAD;
      luma_addr = col_pos + row_pos * stride;
      case (cfg_mode)
         byuv_pkg::MODE_444: begin
            keep = 1'b1;
            chroma_addr = luma_addr;
         end
         byuv_pkg::MODE_420: begin
            keep = (col_pos % 2 == 0) && (row_pos % 2 == 0);
            chroma_addr = (col_pos >> 1) + (row_pos >> 1) * (stride >> 1);
         end
         default: begin
            // 4:2:2 and the reserved mode
            keep = (col_pos % 2 == 0);
            chroma_addr = (col_pos >> 1) + row_pos * (stride >> 1);
         end
      endcase
      row_end = (col_pos + 1) >= w;
      frame_end = row_end && ((row_pos + 1) >= h);

      wr.plane = byuv_pkg::PLANE_LUMA;
      wr.address = 24'(luma_addr);
      wr.sample = q16_to_byte(Y_RED * r + Y_GREEN * g + Y_BLUE * b);
      wr.last_of_pixel = !keep;
      wr.end_of_frame = !keep && frame_end;
      pending_writes.push_back(wr);
      if (keep) begin
         wr.plane = byuv_pkg::PLANE_CHROMA_U;
         wr.address = 24'(chroma_addr);
         wr.sample = q16_to_byte(CHROMA_OFS + U_RED * r + U_GREEN * g + U_BLUE * b);
         wr.last_of_pixel = 1'b0;
         wr.end_of_frame = 1'b0;
         pending_writes.push_back(wr);
         wr.plane = byuv_pkg::PLANE_CHROMA_V;
         wr.sample = q16_to_byte(CHROMA_OFS + V_RED * r + V_GREEN * g + V_BLUE * b);
         wr.last_of_pixel = 1'b1;
         wr.end_of_frame = frame_end;
         pending_writes.push_back(wr);
      end

      if (row_end) begin
         col_pos = 0;
         row_pos = frame_end ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endfunction

   function automatic void check_field(input string what, input int unsigned want, got);
      if (want != got) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endfunction

   function automatic logic [7:0] random_component();
      int pick;
      pick = $urandom_range(7);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'hff;
      return 8'($urandom_range(255));
   endfunction

   // result side: check each write, drive rsp_tready, watch the cycle limit
   always @(posedge clock) begin
      byuv_pkg::wr_type want;
      cycle_count++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_writes.size() == 0) begin
            failures++;
            $display("%0t: unexpected write, expected none, actual plane %0d addr %0d sample %0d",
                     $time, rsp_tuser[1:0], rsp_tdata[23:0], rsp_tdata[31:24]);
         end else begin
            want = pending_writes.pop_front();
            check_field("plane", want.plane, rsp_tuser[1:0]);
            check_field("address", want.address, rsp_tdata[23:0]);
            check_field("sample", want.sample, rsp_tdata[31:24]);
            check_field("last_of_pixel", want.last_of_pixel, rsp_tuser[2]);
            check_field("end_of_frame", want.end_of_frame, rsp_tlast);
            writes_checked++;
         end
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: cycle limit reached with %0d writes outstanding",
                  $time, pending_writes.size());
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_pixel(input logic [7:0] blue, green, red);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {red, green, blue};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_plane_writes(blue, green, red);
      pixels_sent++;
   endtask

   task automatic release_sender();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_writes.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [byuv_pkg::CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         byuv_pkg::REG_FRAME_WIDTH:  cfg_width = val;
         byuv_pkg::REG_FRAME_HEIGHT: cfg_height = val;
         byuv_pkg::REG_CHROMA_MODE:  cfg_mode = val[1:0];
         default: ;
      endcase
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // registers only change with the block idle
   task automatic program_frame(input logic [byuv_pkg::CFG_W-1:0] w, h,
                                input logic [1:0] mode);
      release_sender();
      wait_drained();
      repeat (4) @(posedge clock);
      write_reg(byuv_pkg::REG_FRAME_WIDTH, w);
      write_reg(byuv_pkg::REG_FRAME_HEIGHT, h);
      write_reg(byuv_pkg::REG_CHROMA_MODE, mode);
   endtask

   // primaries and their mixes under the reset setting of 640x480 4:2:0
   task automatic test_color_extremes();
      logic [23:0] swatch [8] = '{24'h000000, 24'hffffff, 24'h0000ff, 24'h00ff00,
                                  24'hff0000, 24'h00ffff, 24'hff00ff, 24'hffff00};
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      foreach (swatch[i]) send_pixel(swatch[i][7:0], swatch[i][15:8], swatch[i][23:16]);
   endtask

   // zero and oversize dimensions, reserved mode, limits shrinking mid-frame
   task automatic test_dimension_limits();
      program_frame(13'd0, 13'd0, byuv_pkg::MODE_444);
      repeat (3) send_pixel(random_component(), random_component(), random_component());
      program_frame(13'h1fff, 13'd4096, MODE_RESERVED);
      repeat (4) send_pixel(random_component(), random_component(), random_component());
      program_frame(13'd1, 13'h1fff, byuv_pkg::MODE_420);
      repeat (5) send_pixel(random_component(), random_component(), random_component());
      program_frame(13'd1, 13'd2, byuv_pkg::MODE_422);
      repeat (2) send_pixel(random_component(), random_component(), random_component());
      // not a register, must change nothing
      release_sender();
      wait_drained();
      repeat (4) @(posedge clock);
      write_reg(REG_UNUSED, 13'h1555);
      send_pixel(8'h5a, 8'ha5, 8'h3c);
   endtask

   task automatic test_random_frames(input int idle_pct, input int stall_pct, input int budget);
      int sent;
      int w;
      int h;
      int count;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      sent = 0;
      while (sent < budget) begin
         w = ($urandom_range(7) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
         h = $urandom_range(5, 1);
         program_frame(13'(w), 13'(h), 2'($urandom_range(3)));
         // mostly whole frames, wide ones cut short
         count = (w * h > 48) ? $urandom_range(48, 20) : w * h * $urandom_range(2, 1);
         for (int i = 0; i < count; i++) begin
            if ($urandom_range(39) == 0) begin
               release_sender();
               wait_drained();
            end
            send_pixel(random_component(), random_component(), random_component());
         end
         sent += count;
      end
      release_sender();
   endtask

   // receiver holds off long enough for the block to back up its input
   task automatic test_receiver_holdoff();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      program_frame(13'd7, 13'd3, byuv_pkg::MODE_444);
      hold_cycles = 250;
      repeat (30) send_pixel(random_component(), random_component(), random_component());
      release_sender();
      wait_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_color_extremes();
      test_dimension_limits();
      test_random_frames(0, 0, 75);
      test_random_frames(55, 0, 75);
      test_random_frames(0, 55, 75);
      test_random_frames(33, 33, 75);
      test_receiver_holdoff();

      release_sender();
      wait_drained();
      repeat (12) @(posedge clock);
      $display("%0d pixels gave %0d checked plane writes over %0d register writes",
               pixels_sent, writes_checked, csr_writes);
      $display("all chroma modes, clamped dimensions, stalls, gaps and a long hold-off");
      if (failures == 0 && pending_writes.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
